>>> hw/rtl/mmpm_pkg.sv
`default_nettype none

package mmpm_pkg;

	localparam int TS_W        = 32;
	localparam int THR_W       = 16;
	localparam int OUT_TOTAL_W = 40;
	localparam int PACE_W      = 48;
	localparam int PACE_SHIFT  = 8;
	localparam int CFG_IDX_W   = 8;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_IDX_W-1:0] REG_MOTION_THRESHOLD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT     = CFG_IDX_W'(1);

	localparam logic [THR_W-1:0] THR_RESET     = THR_W'(410);
	localparam logic [TS_W-1:0]  TIMEOUT_RESET = TS_W'(10000);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MUL,
		ST_SQRT,
		ST_ACC,
		ST_DIV,
		ST_DONE
	} mmpm_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/mmpm_ifs.sv
`default_nettype none

interface mmpm_sample_if import mmpm_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) ();
	logic                          valid;
	logic                          ready;
	logic                          start_req;
	logic [TS_W-1:0]               timestamp_ms;
	logic signed [SAMPLE_BITS-1:0] accel_x;
	logic signed [SAMPLE_BITS-1:0] accel_y;
	logic signed [SAMPLE_BITS-1:0] accel_z;

	modport source (output valid, start_req, timestamp_ms, accel_x, accel_y, accel_z,
		input ready);
	modport sink (input valid, start_req, timestamp_ms, accel_x, accel_y, accel_z,
		output ready);
endinterface

interface mmpm_result_if import mmpm_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [OUT_TOTAL_W-1:0] total_distance;
	logic [TS_W-1:0]        elapsed_ms;
	logic [PACE_W-1:0]      pace;
	logic                   distance_saturated;

	modport source (output valid, total_distance, elapsed_ms, pace, distance_saturated,
		input ready);
	modport sink (input valid, total_distance, elapsed_ms, pace, distance_saturated,
		output ready);
endinterface

interface mmpm_cfg_if import mmpm_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/motion_magnitude_pace_meter_core.sv
`default_nettype none
// An ordinary sample runs from transfer through shift-add squaring and the restoring root
//   and one accumulate step before the core is ready for the next sample.
// A session-ending sample goes from evaluation straight to the pace divide, a restoring
//   divider that yields one quotient bit per cycle, and then waits to load its result.
// Throughput: one sample at a time; a waiting result holds off the input only when a second
//   session ends before the sink takes the first result.
// Reset: arst_n clears the session, the control state and the result slot at once.
module motion_magnitude_pace_meter_core import mmpm_pkg::*; #(
	parameter int SAMPLE_BITS = 16,
	parameter int TOTAL_BITS  = 40
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	mmpm_sample_if.sink    sample,
	mmpm_result_if.source  result,
	mmpm_cfg_if.sink       cfg
);

	// Width plan: deltas fit SAMPLE_BITS unsigned, three squares sum in 2*AW+2 bits,
	// the root in AW+1 bits. The pace dividend is the total shifted up by eight.
	localparam int AW  = SAMPLE_BITS;
	localparam int SQW = 2 * AW + 2;
	localparam int RTW = AW + 1;
	localparam int RMW = AW + 4;
	localparam int DW  = TOTAL_BITS + PACE_SHIFT;
	localparam int CW  = $clog2(DW + 1);
	localparam int MW  = (RTW > TOTAL_BITS) ? RTW : TOTAL_BITS;
	localparam int TW  = (AW > THR_W) ? AW : THR_W;

	mmpm_state_t state_q, state_d;

	// configuration
	logic [THR_W-1:0] thr_q;
	logic [TS_W-1:0]  timeout_q;

	// session state
	logic                   active_q;
	logic [TS_W-1:0]        start_time_q;
	logic [TS_W-1:0]        motion_time_q;
	logic [AW-1:0]          prev_x_q, prev_y_q, prev_z_q;
	logic [TOTAL_BITS-1:0]  total_q;
	logic                   sat_q;

	// captured sample
	logic            start_q;
	logic [TS_W-1:0] ts_q;
	logic [AW-1:0]   x_q, y_q, z_q;

	// serial datapath
	logic [CW-1:0]   cnt_q;
	logic [AW-1:0]   ax_q, ay_q, az_q;
	logic [AW-1:0]   mx_q, my_q, mz_q;
	logic [SQW-1:0]  acc_q;
	logic [RMW-1:0]  rem_q;
	logic [RTW-1:0]  root_q;
	logic [TS_W-1:0] elapsed_q;
	logic [DW-1:0]   dvd_q;
	logic [TS_W-1:0] drem_q;
	logic [PACE_W-1:0] quo_q;
	logic            ovf_q;

	// result slot
	logic                   res_valid_q;
	logic [OUT_TOTAL_W-1:0] res_total_q;
	logic [TS_W-1:0]        res_elapsed_q;
	logic [PACE_W-1:0]      res_pace_q;
	logic                   res_sat_q;

	logic sample_take, res_load;
	logic mul_last, sqrt_last, div_last;

	assign cfg.ready   = 1'b1;
	assign sample_take = sample.valid && sample.ready;
	assign mul_last    = (cnt_q == CW'(AW - 1));
	assign sqrt_last   = (cnt_q == CW'(AW));
	assign div_last    = (cnt_q == CW'(DW - 1));

	// ---- decision for the captured sample
	logic [TS_W-1:0] idle_gap, elapsed_now;
	logic            timed_out;
	assign idle_gap    = ts_q - motion_time_q;
	assign elapsed_now = ts_q - start_time_q;
	assign timed_out   = idle_gap > timeout_q;

	// ---- absolute axis deltas, one sign bit wider for the subtract
	logic [AW:0]   dx, dy, dz, dxn, dyn, dzn;
	logic [AW-1:0] abs_x, abs_y, abs_z;
	logic          moved;
	assign dx  = {x_q[AW-1], x_q} - {prev_x_q[AW-1], prev_x_q};
	assign dy  = {y_q[AW-1], y_q} - {prev_y_q[AW-1], prev_y_q};
	assign dz  = {z_q[AW-1], z_q} - {prev_z_q[AW-1], prev_z_q};
	assign dxn = -dx;
	assign dyn = -dy;
	assign dzn = -dz;
	assign abs_x = dx[AW] ? dxn[AW-1:0] : dx[AW-1:0];
	assign abs_y = dy[AW] ? dyn[AW-1:0] : dy[AW-1:0];
	assign abs_z = dz[AW] ? dzn[AW-1:0] : dz[AW-1:0];
	assign moved = (TW'(abs_x) > TW'(thr_q)) || (TW'(abs_y) > TW'(thr_q)) ||
		(TW'(abs_z) > TW'(thr_q));

	// ---- squaring: MSB-first shift-add, one multiplier bit of each axis per cycle
	logic [SQW-1:0] acc_mul;
	assign acc_mul = {acc_q[SQW-2:0], 1'b0}
		+ (mx_q[AW-1] ? SQW'(ax_q) : SQW'(0))
		+ (my_q[AW-1] ? SQW'(ay_q) : SQW'(0))
		+ (mz_q[AW-1] ? SQW'(az_q) : SQW'(0));

	// ---- root: two radicand bits per cycle, restoring
	logic [RMW-1:0] rem_shift, trial;
	logic           root_bit;
	assign rem_shift = {rem_q[RMW-3:0], acc_q[SQW-1:SQW-2]};
	assign trial     = RMW'({root_q, 2'b01});
	assign root_bit  = rem_shift >= trial;

	// ---- saturating add: headroom is the bitwise complement of the total
	logic [TOTAL_BITS-1:0] headroom;
	logic                  hit_max;
	assign headroom = ~total_q;
	assign hit_max  = MW'(root_q) >= MW'(headroom);

	// ---- pace divide: one quotient bit per cycle
	logic [TS_W:0] dtrial;
	logic          qbit, high_bit;
	assign dtrial   = {drem_q, dvd_q[DW-1]};
	assign qbit     = dtrial >= {1'b0, elapsed_q};
	assign high_bit = (int'(cnt_q) + PACE_W) < DW;

	// ---- next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sample_take) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (start_q || !active_q) state_d = ST_IDLE;
				else if (timed_out) state_d = ST_DIV;
				else state_d = ST_MUL;
			end
			ST_MUL: begin
				if (mul_last) state_d = ST_SQRT;
			end
			ST_SQRT: begin
				if (sqrt_last) state_d = ST_ACC;
			end
			ST_ACC: begin
				state_d = ST_IDLE;
			end
			ST_DIV: begin
				if (div_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (res_load) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---- handshake outputs
	always_comb begin
		sample.ready = (state_q == ST_IDLE);
		res_load     = (state_q == ST_DONE) && (!res_valid_q || result.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// configuration registers; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= THR_RESET;
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MOTION_THRESHOLD: thr_q <= cfg.data[THR_W-1:0];
				REG_IDLE_TIMEOUT:     timeout_q <= cfg.data[TS_W-1:0];
				default: ;
			endcase
		end
	end

	// capture the transfer
	always_ff @(posedge clk) begin
		if (sample_take) begin
			start_q <= sample.start_req;
			ts_q    <= sample.timestamp_ms;
			x_q     <= sample.accel_x;
			y_q     <= sample.accel_y;
			z_q     <= sample.accel_z;
		end
	end

	// session state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			start_time_q  <= '0;
			motion_time_q <= '0;
			prev_x_q      <= '0;
			prev_y_q      <= '0;
			prev_z_q      <= '0;
			total_q       <= '0;
			sat_q         <= 1'b0;
		end else begin
			if (state_q == ST_EVAL) begin
				if (start_q) begin
					active_q      <= 1'b1;
					start_time_q  <= ts_q;
					motion_time_q <= ts_q;
					prev_x_q      <= x_q;
					prev_y_q      <= y_q;
					prev_z_q      <= z_q;
					total_q       <= '0;
					sat_q         <= 1'b0;
				end else if (active_q) begin
					if (timed_out) begin
						active_q <= 1'b0;
					end else begin
						if (moved) motion_time_q <= ts_q;
						prev_x_q <= x_q;
						prev_y_q <= y_q;
						prev_z_q <= z_q;
					end
				end
			end
			if (state_q == ST_ACC) begin
				if (hit_max) begin
					total_q <= '1;
					sat_q   <= 1'b1;
				end else begin
					total_q <= total_q + TOTAL_BITS'(root_q);
				end
			end
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (state_q)
				ST_MUL:  cnt_q <= mul_last ? '0 : cnt_q + CW'(1);
				ST_SQRT: cnt_q <= cnt_q + CW'(1);
				ST_DIV:  cnt_q <= cnt_q + CW'(1);
				default: cnt_q <= '0;
			endcase
		end
	end

	// serial datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_EVAL: begin
				ax_q      <= abs_x;
				ay_q      <= abs_y;
				az_q      <= abs_z;
				mx_q      <= abs_x;
				my_q      <= abs_y;
				mz_q      <= abs_z;
				acc_q     <= '0;
				rem_q     <= '0;
				root_q    <= '0;
				elapsed_q <= elapsed_now;
				dvd_q     <= {total_q, PACE_SHIFT'(0)};
				drem_q    <= '0;
				quo_q     <= '0;
				ovf_q     <= 1'b0;
			end
			ST_MUL: begin
				acc_q <= acc_mul;
				mx_q  <= {mx_q[AW-2:0], 1'b0};
				my_q  <= {my_q[AW-2:0], 1'b0};
				mz_q  <= {mz_q[AW-2:0], 1'b0};
			end
			ST_SQRT: begin
				acc_q  <= {acc_q[SQW-3:0], 2'b00};
				rem_q  <= root_bit ? rem_shift - trial : rem_shift;
				root_q <= {root_q[RTW-2:0], root_bit};
			end
			ST_DIV: begin
				dvd_q  <= {dvd_q[DW-2:0], 1'b0};
				drem_q <= qbit ? TS_W'(dtrial - {1'b0, elapsed_q}) : dtrial[TS_W-1:0];
				quo_q  <= {quo_q[PACE_W-2:0], qbit};
				if (qbit && high_bit) ovf_q <= 1'b1;
			end
			default: ;
		endcase
	end

	// result slot: hold until the sink takes the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid_q <= 1'b0;
		else if (res_load) res_valid_q <= 1'b1;
		else if (result.ready) res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_total_q   <= OUT_TOTAL_W'(total_q);
			res_elapsed_q <= elapsed_q;
			// zero elapsed time or an overflowing quotient pins the pace at its maximum
			res_pace_q    <= (elapsed_q == '0 || ovf_q) ? '1 : quo_q;
			res_sat_q     <= sat_q;
		end
	end

	assign result.valid              = res_valid_q;
	assign result.total_distance     = res_total_q;
	assign result.elapsed_ms         = res_elapsed_q;
	assign result.pace               = res_pace_q;
	assign result.distance_saturated = res_sat_q;

	// ---- checks
	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result slot filled outside the done state");

	a_end_from_eval: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(active_q) |-> $past(state_q) == ST_EVAL)
		else $error("session closed outside evaluation");

	a_sat_means_max: assert property (@(posedge clk) disable iff (!arst_n)
		sat_q |-> &total_q)
		else $error("saturation flag set below the maximum total");

	a_total_update: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(total_q) |-> ($past(state_q) == ST_ACC || $past(state_q) == ST_EVAL))
		else $error("distance total moved outside accumulate or start");

endmodule

`default_nettype wire
